[hw/rtl/assert_macros.svh]
// assertion macros used by the checker file mcm_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every sampled clock edge outside reset
`define MCM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// antecedent sequence followed in the next cycle by the consequent
`define MCM_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("%m: assertion failed");

`endif

[hw/rtl/mcm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcm_pkg
// Types and constants for the 4x4 column matrix multiplier.
// ----------------------------------------------------------------------------
package mcm_pkg;

    localparam int MCM_DIM       = 4;
    localparam int MCM_DATA_W    = 32;
    localparam int MCM_PROD_W    = 2 * MCM_DATA_W;
    localparam int MCM_SUM_W     = MCM_PROD_W + 2;
    localparam int MCM_FRAC_BITS = 16;
    localparam int MCM_ENTRIES   = MCM_DIM * MCM_DIM;

    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_MULTIPLY = 1'b1;

    typedef struct packed {
        logic              command;
        logic [1:0]        column;
        logic signed [31:0] value_row0;
        logic signed [31:0] value_row1;
        logic signed [31:0] value_row2;
        logic signed [31:0] value_row3;
    } t_mcm_in;

    typedef struct packed {
        logic [1:0]        result_column;
        logic signed [31:0] result_row0;
        logic signed [31:0] result_row1;
        logic signed [31:0] result_row2;
        logic signed [31:0] result_row3;
        logic              saturated;
    } t_mcm_out;

    typedef struct packed {
        logic signed [MCM_DATA_W-1:0] value;
        logic                         sat;
    } t_lane_res;

endpackage

[hw/rtl/mcm_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcm_lane
// One result row: four multipliers, a registered full-width sum, then the
// fraction shift and saturation to 32 bits.
// ----------------------------------------------------------------------------
module mcm_lane
    import mcm_pkg::*;
#(
    parameter int FRAC_BITS = MCM_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [MCM_DATA_W-1:0] i_row [MCM_DIM],
    input  logic signed [MCM_DATA_W-1:0] i_vec [MCM_DIM],
    output t_lane_res                    o_res
);

    logic signed [MCM_PROD_W-1:0] r_prod [MCM_DIM];
    logic signed [MCM_SUM_W-1:0]  r_sum;
    logic signed [MCM_SUM_W-1:0]  n_sum;
    logic signed [MCM_SUM_W-1:0]  shifted;
    logic                         fits;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < MCM_DIM; i++) begin
                r_prod[i] <= MCM_PROD_W'(i_row[i]) * MCM_PROD_W'(i_vec[i]);
            end
            r_sum <= n_sum;
        end
    end

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < MCM_DIM; i++) begin
            n_sum = n_sum + MCM_SUM_W'(r_prod[i]);
        end
    end

    // arithmetic shift rounds toward minus infinity
    assign shifted = r_sum >>> FRAC_BITS;
    assign fits    = (shifted[MCM_SUM_W-1:MCM_DATA_W-1] == '0)
                  || (shifted[MCM_SUM_W-1:MCM_DATA_W-1] == '1);

    always_comb begin
        o_res.sat = !fits;
        if (fits) begin
            o_res.value = shifted[MCM_DATA_W-1:0];
        end else if (shifted[MCM_SUM_W-1]) begin
            o_res.value = {1'b1, {(MCM_DATA_W-1){1'b0}}};
        end else begin
            o_res.value = {1'b0, {(MCM_DATA_W-1){1'b1}}};
        end
    end

endmodule

[hw/rtl/matrix4_column_multiply.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4_column_multiply
// Stored 4x4 left matrix times a streamed right-matrix column, signed Q16.16.
// ----------------------------------------------------------------------------
// One transaction per clock in either command while the output is not
// stalled. A load transaction writes one column of the left matrix at the
// accepting edge and gives no result; a multiply transaction uses the matrix
// as it stands at that edge. Four row lanes of four 32x32 multipliers each
// run side by side: the products register at the accepting edge, then the
// full-width sum, then shift and saturation into the output register, from
// which the result is offered until it leaves.
// The pipeline only holds when the output register is full and stalled; the
// left matrix resets to zero.
module matrix4_column_multiply
    import mcm_pkg::*;
#(
    parameter int FRAC_BITS = MCM_FRAC_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_mcm_in  i_item,
    output logic     o_stall,
    output logic     o_valid,
    output t_mcm_out o_result,
    input  logic     i_stall
);

    logic signed [MCM_DATA_W-1:0] r_left [MCM_ENTRIES];
    logic signed [MCM_DATA_W-1:0] vec    [MCM_DIM];
    logic signed [MCM_DATA_W-1:0] rows   [MCM_DIM][MCM_DIM];
    t_lane_res                    lane_res [MCM_DIM];

    logic       r_v1, r_v2, r_out_valid;
    logic [1:0] r_col1, r_col2;
    t_mcm_out   r_out;
    t_mcm_out   n_out;
    logic       advance;
    logic       accept;

    assign vec[0] = i_item.value_row0;
    assign vec[1] = i_item.value_row1;
    assign vec[2] = i_item.value_row2;
    assign vec[3] = i_item.value_row3;

    assign o_stall = r_out_valid && i_stall;
    assign advance = !o_stall;
    assign accept  = i_valid && advance;

    // column-major storage: entry column*4 + row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < MCM_ENTRIES; e++) begin
                r_left[e] <= '0;
            end
        end else if (accept && (i_item.command == CMD_LOAD)) begin
            for (int r = 0; r < MCM_DIM; r++) begin
                r_left[{i_item.column, 2'(r)}] <= vec[r];
            end
        end
    end

    always_comb begin
        for (int r = 0; r < MCM_DIM; r++) begin
            for (int c = 0; c < MCM_DIM; c++) begin
                rows[r][c] = r_left[{2'(c), 2'(r)}];
            end
        end
    end

    for (genvar g = 0; g < MCM_DIM; g++) begin : g_lane
        mcm_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk (i_clk),
            .i_en  (advance),
            .i_row (rows[g]),
            .i_vec (vec),
            .o_res (lane_res[g])
        );
    end

    // merge the four rows into one result column
    always_comb begin
        n_out.result_column = r_col2;
        n_out.result_row0   = lane_res[0].value;
        n_out.result_row1   = lane_res[1].value;
        n_out.result_row2   = lane_res[2].value;
        n_out.result_row3   = lane_res[3].value;
        n_out.saturated     = lane_res[0].sat | lane_res[1].sat
                            | lane_res[2].sat | lane_res[3].sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_v1        <= i_valid && (i_item.command == CMD_MULTIPLY);
            r_v2        <= r_v1;
            r_out_valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_col1 <= i_item.column;
            r_col2 <= r_col1;
            r_out  <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

[hw/rtl/mcm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcm_checker
// Port-level checks for the column matrix multiplier, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcm_checker
    import mcm_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_valid,
    input t_mcm_in  i_item,
    input logic     o_stall,
    input logic     o_valid,
    input t_mcm_out o_result,
    input logic     i_stall
);

    `MCM_ASSERT_NEXT(a_out_valid_holds, i_clk, i_rst_n, o_valid && i_stall, o_valid)

    `MCM_ASSERT_NEXT(a_out_payload_holds, i_clk, i_rst_n, o_valid && i_stall, $stable(o_result))

    // input side only backs up when a finished result is held
    `MCM_ASSERT(a_stall_cause, i_clk, i_rst_n, !o_stall || (o_valid && i_stall))

    // a multiply transaction comes out with its column when nothing stalls
    `MCM_ASSERT_NEXT(a_multiply_latency, i_clk, i_rst_n, (i_valid && !o_stall && (i_item.command == CMD_MULTIPLY)) ##1 !i_stall ##1 !i_stall, o_valid && (o_result.result_column == $past(i_item.column, 3)))

endmodule

bind matrix4_column_multiply mcm_checker u_mcm_checker (.*);
